// File: rtl/xtea_pkg.sv
// Shared types, constants and the XTEA mixing function for the XTEA cipher.
// No dependencies; the cell, the top level and the testbench import this package.
package xtea_pkg;

  // Round constant of the key schedule
  localparam logic [31:0] XteaDelta = 32'h9e37_79b9;

  // Opcode of an input block
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgKeyWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord3 = 3'd3;

  // Four 32-bit key words
  typedef logic [3:0][31:0] xtea_key_t;

  // One block in flight through the cell chain
  typedef struct packed {
    logic        opcode;
    logic [31:0] v0;
    logic [31:0] v1;
  } xtea_blk_t;

  // Shift-xor-add mix of one word
  function automatic logic [31:0] xtea_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// File: rtl/xtea_in_if.sv
// Input channel of the XTEA cipher: valid/ready handshake and block payload.
// No dependencies.
interface xtea_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] word_first;
  logic [31:0] word_second;

  modport source (output valid, output opcode, output word_first, output word_second,
                  input ready);
  modport sink (input valid, input opcode, input word_first, input word_second,
                output ready);
endinterface

// File: rtl/xtea_out_if.sv
// Output channel of the XTEA cipher: valid/ready handshake and result payload.
// No dependencies.
interface xtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_first;
  logic [31:0] out_second;

  modport source (output valid, output out_first, output out_second, input ready);
  modport sink (input valid, input out_first, input out_second, output ready);
endinterface

// File: rtl/xtea_cell.sv
// One registered XTEA half-round; the cipher chains 2*NumCycles of these.
// Depends on xtea_pkg.
module xtea_cell #(
  parameter int unsigned NumCycles = 32,
  parameter int unsigned Half      = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  xtea_pkg::xtea_blk_t blk_i,
  input  xtea_pkg::xtea_key_t key_i,
  output logic               valid_o,
  output xtea_pkg::xtea_blk_t blk_o
);
  import xtea_pkg::*;

  // Schedule sums of this half-round, fixed at elaboration
  localparam int unsigned  IsOdd   = Half % 2;
  localparam int unsigned  EncK    = (Half + 1) / 2;
  localparam int unsigned  DecK    = NumCycles - (Half + 1) / 2;
  localparam logic [63:0]  EncProd = 64'(XteaDelta) * 64'(EncK);
  localparam logic [63:0]  DecProd = 64'(XteaDelta) * 64'(DecK);
  localparam logic [31:0]  EncSum  = EncProd[31:0];
  localparam logic [31:0]  DecSum  = DecProd[31:0];
  localparam logic [1:0]   EncIdx  = (IsOdd == 1) ? EncSum[12:11] : EncSum[1:0];
  localparam logic [1:0]   DecIdx  = (IsOdd == 1) ? DecSum[1:0]   : DecSum[12:11];
  localparam logic         OddBit  = (IsOdd == 1) ? 1'b1 : 1'b0;

  logic        valid_q;
  xtea_blk_t   blk_q, blk_d;
  logic        upd_first;
  logic [31:0] src, tgt, sum, kw, f, res;

  // Pick the word to update and compute the round function
  always_comb begin
    upd_first = (blk_i.opcode == OddBit);
    src       = upd_first ? blk_i.v1 : blk_i.v0;
    tgt       = upd_first ? blk_i.v0 : blk_i.v1;
    sum       = (blk_i.opcode == OpDecrypt) ? DecSum : EncSum;
    kw        = (blk_i.opcode == OpDecrypt) ? key_i[DecIdx] : key_i[EncIdx];
    f         = xtea_mix(src) ^ (sum + kw);
    res       = (blk_i.opcode == OpDecrypt) ? (tgt - f) : (tgt + f);
    blk_d     = blk_i;
    if (upd_first) begin
      blk_d.v0 = res;
    end else begin
      blk_d.v1 = res;
    end
  end

  // Advance the valid bit with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance the payload with the chain
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;
endmodule

// File: rtl/xtea_block_cipher_top.sv
// Top level of the XTEA block cipher: key registers, cell chain, output and skid stage.
// Depends on xtea_pkg, xtea_in_if, xtea_out_if and xtea_cell.
//
// Encrypts (opcode 0) or decrypts (opcode 1) one 64-bit block per transfer under a
// 128-bit key held in four configuration words, applying NumCycles XTEA rounds. The
// block accepts one block every clock cycle while the skid register is empty; a
// result passes through a chain of 2*NumCycles registered half-round cells: the
// transfer edge loads the first cell, and the output register follows the last cell.
// When the output is stalled, one further result is caught in a skid register and
// the input then deasserts ready until the skid register drains. Write keys only
// while idle.
module xtea_block_cipher_top #(
  parameter int unsigned NumCycles = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  xtea_in_if.sink                       blk_in,
  xtea_out_if.source                    blk_out
);
  import xtea_pkg::*;

  localparam int unsigned NumCells = 2 * NumCycles;

  xtea_key_t key_q;
  logic      en;
  logic      out_fire;
  logic      last_valid;
  xtea_blk_t last_blk;
  logic      out_valid_q, skid_valid_q;
  xtea_blk_t out_blk_q, skid_blk_q;

  logic      [NumCells:0] chain_valid;
  xtea_blk_t [NumCells:0] chain_blk;

  // Key registers; writes beyond the last key word are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgKeyWord0: key_q[0] <= cfg_data_i;
        CfgKeyWord1: key_q[1] <= cfg_data_i;
        CfgKeyWord2: key_q[2] <= cfg_data_i;
        CfgKeyWord3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Chain advances whenever the skid register is empty
  assign en           = !skid_valid_q;
  assign blk_in.ready = en;
  assign out_fire     = out_valid_q && blk_out.ready;

  assign chain_valid[0]     = blk_in.valid;
  assign chain_blk[0].opcode = blk_in.opcode;
  assign chain_blk[0].v0     = blk_in.word_first;
  assign chain_blk[0].v1     = blk_in.word_second;

  // Row of half-round cells
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    xtea_cell #(
      .NumCycles (NumCycles),
      .Half      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .blk_i   (chain_blk[g]),
      .key_i   (key_q),
      .valid_o (chain_valid[g+1]),
      .blk_o   (chain_blk[g+1])
    );
  end

  assign last_valid = chain_valid[NumCells];
  assign last_blk   = chain_blk[NumCells];

  // Output and skid control: drain skid first, else take the chain's last stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (last_valid) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_blk_q <= skid_blk_q;
      end
    end else if (last_valid) begin
      if (!out_valid_q || out_fire) begin
        out_blk_q <= last_blk;
      end else begin
        skid_blk_q <= last_blk;
      end
    end
  end

  assign blk_out.valid      = out_valid_q;
  assign blk_out.out_first  = out_blk_q.v0;
  assign blk_out.out_second = out_blk_q.v1;

  // A held skid entry always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while output is empty");

  // Skid fills only when the output was stalled
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !blk_out.ready && last_valid))
    else $error("skid register filled without an output stall");

  // A finished block meeting a stalled output must land in the skid register
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && last_valid && out_valid_q && !blk_out.ready) |=> skid_valid_q)
    else $error("finished block lost at a stalled output");
endmodule

// File: test/xtea_block_cipher_top_tb.sv
// Self-checking testbench for xtea_block_cipher_top: random valid/ready traffic on both sides,
// with results checked against an in-bench XTEA encrypt/decrypt predictor under several keys.
// Depends on xtea_pkg, xtea_in_if, xtea_out_if and the block's RTL.
module xtea_block_cipher_top_tb;
  import xtea_pkg::*;

  localparam int unsigned Rounds       = 32;
  localparam int unsigned NumKeyWords  = 4;
  localparam int unsigned Latency      = 2 * Rounds + 1;
  localparam int unsigned PhaseBlocks  = 345;
  localparam int unsigned MaxReports   = 10;
  localparam longint unsigned CycleLimit = 200000;

  // Corner word pairs, each queued twice, once with each opcode
  localparam logic [31:0] CornerFirst [6] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000,
                                              32'h8000_0000, 32'haaaa_aaaa, 32'h0123_4567};
  localparam logic [31:0] CornerSecond [6] = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff,
                                               32'h0000_0001, 32'h5555_5555, 32'h89ab_cdef};

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } word_pair_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [31:0]         cfg_data_i;

  xtea_in_if  blk_in_if ();
  xtea_out_if blk_out_if ();

  xtea_block_cipher_top #(
    .NumCycles(Rounds)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .blk_in     (blk_in_if),
    .blk_out    (blk_out_if)
  );

  // Key words as the block should hold them
  logic [31:0] key_model [NumKeyWords];

  xtea_blk_t   pending_blocks [$];
  word_pair_t  expected_words [$];

  bit          in_fire;
  bit          out_fire;
  bit          in_burst;
  bit          out_burst;
  int unsigned in_wait;
  int unsigned out_wait;
  int unsigned blocks_queued;
  int unsigned blocks_sent;
  int unsigned decrypts_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned key_sets;
  longint unsigned cycle_count;

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] feistel_mix(logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Run the full XTEA cycle count on one block under the current key
  function automatic word_pair_t xtea_transform(xtea_blk_t blk);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    a = blk.v0;
    b = blk.v1;
    if (blk.opcode == OpEncrypt) begin
      sum = '0;
      for (int unsigned i = 0; i < Rounds; i++) begin
        a += feistel_mix(b) ^ (sum + key_model[sum[1:0]]);
        sum += XteaDelta;
        b += feistel_mix(a) ^ (sum + key_model[sum[12:11]]);
      end
    end else begin
      // start sum wraps modulo 2^32
      sum = XteaDelta * Rounds;
      for (int unsigned i = 0; i < Rounds; i++) begin
        b -= feistel_mix(a) ^ (sum + key_model[sum[12:11]]);
        sum -= XteaDelta;
        a -= feistel_mix(b) ^ (sum + key_model[sum[1:0]]);
      end
    end
    return {a, b};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 23))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_block(xtea_blk_t blk);
    pending_blocks.push_back(blk);
    blocks_queued++;
  endtask

  // Wait until every queued block has come back
  task automatic drain();
    while (words_checked != blocks_queued) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx < NumKeyWords) key_model[idx[1:0]] = data;
  endtask

  task automatic load_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2, logic [31:0] k3);
    write_cfg(CfgKeyWord0, k0);
    write_cfg(CfgKeyWord1, k1);
    write_cfg(CfgKeyWord2, k2);
    write_cfg(CfgKeyWord3, k3);
    // writes to unused indexes must leave the key alone
    for (int unsigned j = NumKeyWords; j < 2 ** CfgIdxW; j++) begin
      write_cfg(CfgIdxW'(j), $urandom());
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    key_sets++;
  endtask

  task automatic queue_corners();
    @(posedge clk_i);
    for (int unsigned i = 0; i < 6; i++) begin
      queue_block('{opcode: OpEncrypt, v0: CornerFirst[i], v1: CornerSecond[i]});
      queue_block('{opcode: OpDecrypt, v0: CornerFirst[i], v1: CornerSecond[i]});
    end
  endtask

  // Random blocks, often followed by the decryption of their own ciphertext
  task automatic random_blocks(int unsigned count);
    xtea_blk_t   blk;
    word_pair_t  enc;
    int unsigned n;
    @(posedge clk_i);
    n = 0;
    while (n < count) begin
      blk.opcode = $urandom_range(0, 1) ? OpDecrypt : OpEncrypt;
      blk.v0     = pick_word();
      blk.v1     = pick_word();
      queue_block(blk);
      n++;
      if (blk.opcode == OpEncrypt && $urandom_range(0, 3) == 0) begin
        enc = xtea_transform(blk);
        queue_block('{opcode: OpDecrypt, v0: enc.first, v1: enc.second});
        n++;
      end
    end
  endtask

  // Check output transfers, then predict input transfers
  always @(posedge clk_i) begin
    word_pair_t got;
    word_pair_t want;
    if (rst_ni) begin
      if (blk_out_if.valid && blk_out_if.ready) begin
        got = {blk_out_if.out_first, blk_out_if.out_second};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("ERROR: result first %h second %h with none expected",
                     got.first, got.second);
        end else begin
          want = expected_words.pop_front();
          if (got.first !== want.first || got.second !== want.second) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("ERROR: result %0d: expected first %h second %h, got first %h second %h",
                       words_checked, want.first, want.second, got.first, got.second);
          end
          words_checked++;
        end
      end
      if (blk_in_if.valid && blk_in_if.ready) begin
        expected_words.push_back(xtea_transform('{opcode: blk_in_if.opcode,
                                                  v0: blk_in_if.word_first,
                                                  v1: blk_in_if.word_second}));
        blocks_sent++;
        if (blk_in_if.opcode == OpDecrypt) decrypts_sent++;
      end
    end
    in_fire  <= rst_ni && blk_in_if.valid && blk_in_if.ready;
    out_fire <= rst_ni && blk_out_if.valid && blk_out_if.ready;
  end

  // Input driver: hold each block until its transfer, then idle a random while
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      blk_in_if.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        void'(pending_blocks.pop_front());
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        in_wait = in_burst ? 0 : $urandom_range(0, 9);
      end
      if (in_wait > 0) begin
        in_wait--;
        blk_in_if.valid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        blk_in_if.valid       <= 1'b1;
        blk_in_if.opcode      <= pending_blocks[0].opcode;
        blk_in_if.word_first  <= pending_blocks[0].v0;
        blk_in_if.word_second <= pending_blocks[0].v1;
      end else begin
        blk_in_if.valid <= 1'b0;
      end
    end
  end

  // Output side: stall a random while after each result transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      blk_out_if.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (out_wait > 0) begin
        out_wait--;
        blk_out_if.ready <= 1'b0;
      end else begin
        blk_out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ERROR: run did not finish within %0d cycles", CycleLimit);
      $display("FAIL xtea_block_cipher_top");
      $finish;
    end
  end

  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = '0;
    cfg_data_i            = '0;
    blk_in_if.valid       = 1'b0;
    blk_in_if.opcode      = OpEncrypt;
    blk_in_if.word_first  = '0;
    blk_in_if.word_second = '0;
    blk_out_if.ready      = 1'b0;
    in_fire               = 1'b0;
    out_fire              = 1'b0;
    in_burst              = 1'b0;
    out_burst             = 1'b0;
    in_wait               = 0;
    out_wait              = 0;
    blocks_queued         = 0;
    blocks_sent           = 0;
    decrypts_sent         = 0;
    words_checked         = 0;
    mismatches            = 0;
    key_sets              = 1;
    cycle_count           = 0;
    for (int unsigned i = 0; i < NumKeyWords; i++) key_model[i] = '0;

    // Hold reset, then release it at a falling clock edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Corner blocks under the reset key, then under the all-ones key
    queue_corners();
    drain();
    load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_corners();
    drain();

    // Random traffic under a series of keys
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    random_blocks(PhaseBlocks);
    drain();
    load_key(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0000, 32'hffff_ffff);
    random_blocks(PhaseBlocks);
    drain();
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    random_blocks(PhaseBlocks);
    drain();
    load_key(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'hffff_fffe);
    random_blocks(PhaseBlocks);
    drain();

    // Let any stray result show up
    repeat (Latency + 16) @(negedge clk_i);

    $display("Sent %0d blocks (%0d decrypts) under %0d keys; %0d results checked, %0d mismatches",
             blocks_sent, decrypts_sent, key_sets, words_checked, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS xtea_block_cipher_top");
    end else begin
      $display("FAIL xtea_block_cipher_top");
    end
    $finish;
  end

endmodule
